// File: sv/cir2d_pkg.sv
// Shared types, widths and helpers for the 2D collision impulse resolver.
// No dependencies; imported by every module of the block.
package cir2d_pkg;

    // working width of position/velocity accumulators (holds the largest delta)
    localparam int WW = 44;
    // relative normal velocity width (exact Q32 dot product)
    localparam int RW = 54;
    // shared multiply/divide unit geometry
    localparam int MA_W   = 40;
    localparam int MB_W   = 18;
    localparam int MP_W   = MA_W + MB_W;
    localparam int DVD_W  = 32;
    localparam int DVS_W  = 33;
    localparam int QUO_W  = 16;
    localparam int CNT_W  = 5;
    localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(MB_W);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(QUO_W);
    localparam logic [MB_W-1:0]  ONE_Q16   = MB_W'(65536);

    typedef enum logic [3:0] {
        OP_SEPX, OP_SEPY, OP_RVX, OP_RVY, OP_Q, OP_RA, OP_RB,
        OP_DA, OP_DB, OP_AVX, OP_AVY, OP_BVX, OP_BVY
    } op_t;

    typedef struct packed {
        logic latch_a;
        logic load_b;
        logic start;
        op_t  op;
        logic sel_b;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic relv_neg;
        logic held_valid;
    } dp_sts_t;

    function automatic logic [31:0] sat32(input logic [WW-1:0] v);
        logic [WW-32:0] hi;
        hi = v[WW-1:31];
        if ((&hi) || !(|hi))
            return v[31:0];
        return v[WW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    endfunction

endpackage

// File: sv/cir2d_mdu.sv
// Shared multiply/divide unit: radix-2 shift-add multiplier and restoring divider.
// Depends on cir2d_pkg.
module cir2d_mdu
    import cir2d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              is_div,
    input  logic [MA_W-1:0]   opa,
    input  logic [MB_W-1:0]   opb,
    input  logic [DVD_W-1:0]  dvd,
    input  logic [DVS_W-1:0]  dvs,
    output logic              done,
    output logic [MP_W-1:0]   prod,
    output logic [QUO_W-1:0]  quo
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              div_reg;
    logic [MA_W-1:0]   mcand_reg;
    logic [MP_W:0]     p_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [QUO_W-1:0]  quo_reg;

    logic [MA_W:0]     psum;
    logic [DVS_W:0]    trial;
    logic              ge;

    assign psum  = p_reg[MP_W:MB_W] + {1'b0, mcand_reg};
    assign trial = {rem_reg, 1'b0};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = is_div ? DIV_STEPS : MUL_STEPS;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg   <= is_div;
            mcand_reg <= opa;
            p_reg     <= {{(MA_W+1){1'b0}}, opb};
            rem_reg   <= {1'b0, dvd};
            dvs_reg   <= dvs;
            quo_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                rem_reg <= ge ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], ge};
            end
            else
            begin
                p_reg <= {1'b0, p_reg[0] ? psum : {1'b0, p_reg[MP_W-1:MB_W]},
                          p_reg[MB_W-1:1]};
            end
        end
    end

    assign done = done_reg;
    assign prod = p_reg[MP_W-1:0];
    assign quo  = quo_reg;

endmodule

// File: sv/cir2d_dp.sv
// Datapath: latched body A, body B and contact data, working accumulators,
// operand selection for the shared multiply/divide unit. Depends on cir2d_pkg, cir2d_mdu.
module cir2d_dp
    import cir2d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_sts_t            sts,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic [31:0]        mass,
    input  logic [16:0]        restitution,
    input  logic               inert,
    input  logic signed [17:0] normal_x,
    input  logic signed [17:0] normal_y,
    input  logic [30:0]        depth,
    output logic signed [31:0] new_pos_x,
    output logic signed [31:0] new_pos_y,
    output logic signed [31:0] new_vel_x,
    output logic signed [31:0] new_vel_y
);

    logic              held_valid_reg;
    logic [31:0]       held_pos_x_reg, held_pos_y_reg, held_vel_x_reg, held_vel_y_reg;
    logic [31:0]       held_mass_reg, b_mass_reg;
    logic [16:0]       held_rest_reg, b_rest_reg;
    logic              held_inert_reg, b_inert_reg;
    logic [17:0]       nx_reg, ny_reg;
    logic [30:0]       depth_reg;
    logic [WW-1:0]     ax_reg, ay_reg, avx_reg, avy_reg;
    logic [WW-1:0]     bx_reg, by_reg, bvx_reg, bvy_reg;
    logic [RW-1:0]     relv_reg;
    logic [37:0]       q_reg;
    logic [QUO_W-1:0]  ra_reg, rb_reg;
    logic [38:0]       da_reg, db_reg;
    logic              sgn_reg;

    logic              mdu_done;
    logic [MP_W-1:0]   prod;
    logic [QUO_W-1:0]  quo;
    logic [MA_W-1:0]   opa;
    logic [MB_W-1:0]   opb;
    logic [DVD_W-1:0]  dvd;
    logic              is_div, sgn;

    logic [17:0]       nx_mag, ny_mag;
    logic [32:0]       dvx, dvy, dvx_mag, dvy_mag;
    logic [RW-1:0]     relv_mag, rv_mag, rv_s;
    logic [16:0]       e_min;
    logic [31:0]       ma_eff, mb_eff;
    logic [DVS_W-1:0]  msum;
    logic              half;
    logic [WW-1:0]     sep_mag, sep_s, dv_mag, dv_s;

    assign nx_mag   = nx_reg[17] ? 18'(-nx_reg) : nx_reg;
    assign ny_mag   = ny_reg[17] ? 18'(-ny_reg) : ny_reg;
    assign dvx      = {avx_reg[31], avx_reg[31:0]} - {bvx_reg[31], bvx_reg[31:0]};
    assign dvy      = {avy_reg[31], avy_reg[31:0]} - {bvy_reg[31], bvy_reg[31:0]};
    assign dvx_mag  = dvx[32] ? 33'(-dvx) : dvx;
    assign dvy_mag  = dvy[32] ? 33'(-dvy) : dvy;
    assign relv_mag = RW'(-relv_reg);
    assign e_min    = (held_rest_reg < b_rest_reg) ? held_rest_reg : b_rest_reg;
    assign ma_eff   = (held_mass_reg == '0) ? 32'd1 : held_mass_reg;
    assign mb_eff   = (b_mass_reg == '0) ? 32'd1 : b_mass_reg;
    assign msum     = {1'b0, ma_eff} + {1'b0, mb_eff};
    assign half     = !(held_inert_reg || b_inert_reg);

    // operand select per step
    always_comb
    begin
        opa    = '0;
        opb    = '0;
        dvd    = '0;
        is_div = 1'b0;
        sgn    = 1'b0;
        unique case (cmd.op)
            OP_SEPX: begin opa = MA_W'(depth_reg); opb = nx_mag; sgn = nx_reg[17]; end
            OP_SEPY: begin opa = MA_W'(depth_reg); opb = ny_mag; sgn = ny_reg[17]; end
            OP_RVX:  begin opa = MA_W'(dvx_mag); opb = nx_mag; sgn = dvx[32] ^ nx_reg[17]; end
            OP_RVY:  begin opa = MA_W'(dvy_mag); opb = ny_mag; sgn = dvy[32] ^ ny_reg[17]; end
            OP_Q:    begin opa = MA_W'(relv_mag[RW-1:16]); opb = ONE_Q16 + MB_W'(e_min); end
            OP_RA:   begin is_div = 1'b1; dvd = mb_eff; end
            OP_RB:   begin is_div = 1'b1; dvd = ma_eff; end
            OP_DA:   begin opa = MA_W'(q_reg); opb = MB_W'(ra_reg); end
            OP_DB:   begin opa = MA_W'(q_reg); opb = MB_W'(rb_reg); end
            OP_AVX, OP_BVX: begin opa = MA_W'(cmd.op == OP_AVX ? da_reg : db_reg);
                                  opb = nx_mag; sgn = nx_reg[17]; end
            OP_AVY, OP_BVY: begin opa = MA_W'(cmd.op == OP_AVY ? da_reg : db_reg);
                                  opb = ny_mag; sgn = ny_reg[17]; end
            default: begin opa = '0; end
        endcase
    end

    cir2d_mdu u_mdu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.start),
        .is_div (is_div),
        .opa    (opa),
        .opb    (opb),
        .dvd    (dvd),
        .dvs    (msum),
        .done   (mdu_done),
        .prod   (prod),
        .quo    (quo)
    );

    // signed results of the finished product, truncated toward zero
    assign sep_mag = half ? WW'(prod[MP_W-1:17]) : WW'(prod[MP_W-1:16]);
    assign sep_s   = sgn_reg ? WW'(-sep_mag) : sep_mag;
    assign rv_mag  = RW'(prod);
    assign rv_s    = sgn_reg ? RW'(-rv_mag) : rv_mag;
    assign dv_mag  = WW'(prod[MP_W-1:16]);
    assign dv_s    = sgn_reg ? WW'(-dv_mag) : dv_mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_valid_reg <= 1'b0;
        else if (cmd.latch_a)
            held_valid_reg <= 1'b1;
        else if (cmd.load_b)
            held_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_a)
        begin
            held_pos_x_reg <= pos_x;
            held_pos_y_reg <= pos_y;
            held_vel_x_reg <= vel_x;
            held_vel_y_reg <= vel_y;
            held_mass_reg  <= mass;
            held_rest_reg  <= restitution;
            held_inert_reg <= inert;
        end
        if (cmd.load_b)
        begin
            ax_reg      <= {{(WW-32){held_pos_x_reg[31]}}, held_pos_x_reg};
            ay_reg      <= {{(WW-32){held_pos_y_reg[31]}}, held_pos_y_reg};
            avx_reg     <= {{(WW-32){held_vel_x_reg[31]}}, held_vel_x_reg};
            avy_reg     <= {{(WW-32){held_vel_y_reg[31]}}, held_vel_y_reg};
            bx_reg      <= {{(WW-32){pos_x[31]}}, pos_x};
            by_reg      <= {{(WW-32){pos_y[31]}}, pos_y};
            bvx_reg     <= {{(WW-32){vel_x[31]}}, vel_x};
            bvy_reg     <= {{(WW-32){vel_y[31]}}, vel_y};
            b_mass_reg  <= mass;
            b_rest_reg  <= restitution;
            b_inert_reg <= inert;
            nx_reg      <= normal_x;
            ny_reg      <= normal_y;
            depth_reg   <= depth;
        end
        if (cmd.start)
            sgn_reg <= sgn;
        if (mdu_done)
        begin
            unique case (cmd.op)
                OP_SEPX:
                begin
                    if (held_inert_reg)
                        bx_reg <= bx_reg - sep_s;
                    else if (b_inert_reg)
                        ax_reg <= ax_reg + sep_s;
                    else
                    begin
                        ax_reg <= ax_reg + sep_s;
                        bx_reg <= bx_reg - sep_s;
                    end
                end
                OP_SEPY:
                begin
                    if (held_inert_reg)
                        by_reg <= by_reg - sep_s;
                    else if (b_inert_reg)
                        ay_reg <= ay_reg + sep_s;
                    else
                    begin
                        ay_reg <= ay_reg + sep_s;
                        by_reg <= by_reg - sep_s;
                    end
                end
                OP_RVX:  relv_reg <= rv_s;
                OP_RVY:  relv_reg <= relv_reg + rv_s;
                OP_Q:    q_reg    <= prod[53:16];
                OP_RA:   ra_reg   <= quo;
                OP_RB:   rb_reg   <= quo;
                OP_DA:   da_reg   <= prod[54:16];
                OP_DB:   db_reg   <= prod[54:16];
                OP_AVX:  avx_reg  <= avx_reg + dv_s;
                OP_AVY:  avy_reg  <= avy_reg + dv_s;
                OP_BVX:  bvx_reg  <= bvx_reg - dv_s;
                OP_BVY:  bvy_reg  <= bvy_reg - dv_s;
                default: q_reg    <= q_reg;
            endcase
        end
    end

    assign sts.done       = mdu_done;
    assign sts.relv_neg   = relv_reg[RW-1];
    assign sts.held_valid = held_valid_reg;

    assign new_pos_x = sat32(cmd.sel_b ? bx_reg  : ax_reg);
    assign new_pos_y = sat32(cmd.sel_b ? by_reg  : ay_reg);
    assign new_vel_x = sat32(cmd.sel_b ? bvx_reg : avx_reg);
    assign new_vel_y = sat32(cmd.sel_b ? bvy_reg : avy_reg);

endmodule

// File: sv/cir2d_ctrl.sv
// Controller: accepts items, sequences the multiply/divide steps, presents results.
// Depends on cir2d_pkg.
module cir2d_ctrl
    import cir2d_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  logic    action,
    output logic    out_valid,
    input  logic    out_stall,
    output logic    which_body,
    output logic    status,
    output logic    last,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE, S_ISSUE, S_WAIT, S_CHECK, S_OUT_A, S_OUT_B
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   status_reg, status_next;
    logic   in_acc;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && action)
                begin
                    if (sts.held_valid)
                    begin
                        op_next     = OP_SEPX;
                        status_next = 1'b0;
                        state_next  = S_ISSUE;
                    end
                    else
                    begin
                        status_next = 1'b1;
                        state_next  = S_OUT_B;
                    end
                end
            end
            S_ISSUE: state_next = S_WAIT;
            S_WAIT:
            begin
                if (sts.done)
                begin
                    if (op_reg == OP_RVY)
                        state_next = S_CHECK;
                    else if (op_reg == OP_BVY)
                        state_next = S_OUT_A;
                    else
                    begin
                        op_next    = op_t'(op_reg + 4'd1);
                        state_next = S_ISSUE;
                    end
                end
            end
            S_CHECK:
            begin
                // skip the impulse when the bodies already separate
                if (sts.relv_neg)
                begin
                    op_next    = OP_Q;
                    state_next = S_ISSUE;
                end
                else
                    state_next = S_OUT_A;
            end
            S_OUT_A: if (!out_stall) state_next = S_OUT_B;
            S_OUT_B: if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= OP_SEPX;
            status_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            status_reg <= status_next;
        end
    end

    assign out_valid  = (state_reg == S_OUT_A) || (state_reg == S_OUT_B);
    assign which_body = (state_reg == S_OUT_B);
    assign last       = (state_reg == S_OUT_B);
    assign status     = status_reg && (state_reg == S_OUT_B);

    assign cmd.latch_a = in_acc && !action;
    assign cmd.load_b  = in_acc && action;
    assign cmd.start   = (state_reg == S_ISSUE);
    assign cmd.op      = op_reg;
    assign cmd.sel_b   = (state_reg == S_OUT_B);

endmodule

// File: sv/collision_impulse_resolver_2d.sv
// Top level of the 2D collision impulse resolver (Q16.16 fixed point).
// Depends on cir2d_pkg, cir2d_ctrl, cir2d_dp (which holds cir2d_mdu).
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------
//   in      | in_valid / in_stall  | action pos_x pos_y vel_x vel_y mass
//           |                      | restitution inert normal_x normal_y depth
//   out     | out_valid / out_stall| which_body new_pos_x new_pos_y new_vel_x
//           |                      | new_vel_y status last
//
// A body-A item is latched and gives no result. A body-B item, with body A
// held, runs 4 multiplies (each on the shared serial multiplier: issue, one
// shift-add step per multiplier bit, done) and, when the bodies approach, 7 more
// multiplies plus 2 divides, then gives a result for body A and one for body B.
// The shared multiply/divide unit produces one bit of a product or quotient per
// cycle. in_stall stays high from a B item until its last result leaves;
// out_stall holds the current result in place.
// Reset clears the latch of body A and returns the controller to idle.
module collision_impulse_resolver_2d
    import cir2d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic [31:0]        mass,
    input  logic [16:0]        restitution,
    input  logic               inert,
    input  logic signed [17:0] normal_x,
    input  logic signed [17:0] normal_y,
    input  logic [30:0]        depth,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               which_body,
    output logic signed [31:0] new_pos_x,
    output logic signed [31:0] new_pos_y,
    output logic signed [31:0] new_vel_x,
    output logic signed [31:0] new_vel_y,
    output logic               status,
    output logic               last
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequence control and handshakes
    cir2d_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .which_body (which_body),
        .status     (status),
        .last       (last),
        .cmd        (cmd),
        .sts        (sts)
    );

    // body registers, accumulators and the shared arithmetic unit
    cir2d_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .vel_x       (vel_x),
        .vel_y       (vel_y),
        .mass        (mass),
        .restitution (restitution),
        .inert       (inert),
        .normal_x    (normal_x),
        .normal_y    (normal_y),
        .depth       (depth),
        .new_pos_x   (new_pos_x),
        .new_pos_y   (new_pos_y),
        .new_vel_x   (new_vel_x),
        .new_vel_y   (new_vel_y)
    );

    // the final result of an item is always body B
    a_last_is_b: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> which_body)
        else $error("last result not for body B");

    // a missing body A is only reported on the single, final result
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> last)
        else $error("status set on a non-final result");

    // body A result is followed by body B result
    a_a_then_b: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid && which_body)
        else $error("body B result did not follow body A");

    // never take an item while results are pending
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid && !sts.done)
        else $error("input open while busy");

endmodule
